// ----- src/bmtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-matrix transitive closure package
// Shared widths, reset values and configuration register indexes.
// ----------------------------------------------------------------------------
package bmtc_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned ROW_NUM_W       = 5;
  localparam int unsigned CFG_DATA_W      = 6;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned MAX_OBJECTS_DEF = 32;

  localparam logic [CFG_DATA_W-1:0] OBJECT_COUNT_RST = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLEXIVE    = 1'b1;

endpackage

// ----- src/bmtc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-matrix transitive closure channels
// Row input channel and closed-row result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmtc_in_if import bmtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

interface bmtc_out_if import bmtc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    closure_row;
  logic [ROW_NUM_W-1:0] row_number;
  logic                 last_row;

  modport source (output valid, output closure_row, output row_number,
                  output last_row, input ready);
  modport sink   (input valid, input closure_row, input row_number,
                  input last_row, output ready);
endinterface

// ----- src/bit_matrix_transitive_closure.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle while rows load; no new matrix is accepted
//   until the last closed row of the previous one has been taken.
// Output: each closed row is read, captured and held valid until out_o.ready.
// Reset: control state and configuration clear at once; the row memory is
//   not cleared, every row is written before it is read.
// ----------------------------------------------------------------------------
// Bit-matrix transitive closure
// Loads adjacency rows into a row memory, runs Warshall's closure by
// read-modify-write sweeps, one pivot at a time, then streams the rows out (reflexive mode sets the diagonal bit).
// ----------------------------------------------------------------------------
module bit_matrix_transitive_closure import bmtc_pkg::*; #(
  parameter int unsigned MaxObjects = MAX_OBJECTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bmtc_in_if.sink               in_i,
  bmtc_out_if.source            out_o
);

  localparam int unsigned IdxW = $clog2(MaxObjects);
  localparam int unsigned CntW = $clog2(MaxObjects + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_CAP,
    ST_ROW,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_SEND
  } state_e;

  state_e state_q;

  logic [CFG_DATA_W-1:0] obj_count_q;
  logic                  refl_q;

  logic [IdxW-1:0]      load_q;
  logic [IdxW-1:0]      k_q;
  logic [IdxW-1:0]      i_q;
  logic [IdxW-1:0]      wb_idx_q;
  logic                 wb_valid_q;
  logic [DATA_W-1:0]    pivot_q;
  logic                 out_valid_q;
  logic [DATA_W-1:0]    out_row_q;
  logic [ROW_NUM_W-1:0] out_num_q;
  logic                 out_last_q;

  logic [DATA_W-1:0] mem_q [MaxObjects];
  logic [DATA_W-1:0] rdata_q;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;

  logic [6:0]        obj_ext;
  logic [6:0]        n_full;
  logic [CntW-1:0]   n_act;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] rd_masked;
  logic [DATA_W-1:0] upd_row;
  logic              hit;
  logic              in_acc;
  logic              load_more;
  logic              i_last;
  logic              k_last;

  assign obj_ext = {1'b0, obj_count_q};
  assign n_full  = (obj_count_q == '0) ? 7'd1 :
                   (obj_ext > 7'(MaxObjects)) ? 7'(MaxObjects) : obj_ext;
  assign n_act   = CntW'(n_full);
  assign mask    = (DATA_W'(1) << n_act) - DATA_W'(1);

  assign rd_masked = rdata_q & mask;
  assign hit       = |(rd_masked & (DATA_W'(1) << k_q));
  assign upd_row   = rd_masked | (hit ? pivot_q : '0);

  assign in_acc    = in_i.valid && in_i.ready;
  assign load_more = (CntW'(load_q) + CntW'(1)) < n_act;
  assign i_last    = (CntW'(i_q) + CntW'(1)) == n_act;
  assign k_last    = (CntW'(k_q) + CntW'(1)) == n_act;

  assign in_i.ready        = (state_q == ST_LOAD);
  assign out_o.valid       = out_valid_q;
  assign out_o.closure_row = out_row_q;
  assign out_o.row_number  = out_num_q;
  assign out_o.last_row    = out_last_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wb_idx_q;
    mem_wdata = upd_row;
    mem_re    = 1'b0;
    mem_raddr = i_q;
    case (state_q)
      ST_LOAD: begin
        mem_we    = in_acc;
        mem_waddr = load_q;
        mem_wdata = in_i.row_bits;
      end
      ST_PIV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
      end
      ST_ROW: begin
        mem_we = wb_valid_q;
        mem_re = 1'b1;
      end
      ST_DRAIN: begin
        mem_we = 1'b1;
      end
      ST_EMIT_RD: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_count_q <= OBJECT_COUNT_RST;
      refl_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OBJECT_COUNT: obj_count_q <= cfg_wdata_i;
        CFG_REFLEXIVE:    refl_q      <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_q      <= '0;
      k_q         <= '0;
      i_q         <= '0;
      wb_idx_q    <= '0;
      wb_valid_q  <= 1'b0;
      pivot_q     <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_num_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (load_more) begin
              load_q <= load_q + IdxW'(1);
            end else begin
              load_q  <= '0;
              k_q     <= '0;
              state_q <= ST_PIV_RD;
            end
          end
        end
        ST_PIV_RD: begin
          state_q <= ST_PIV_CAP;
        end
        ST_PIV_CAP: begin
          pivot_q    <= rd_masked;
          i_q        <= '0;
          wb_valid_q <= 1'b0;
          state_q    <= ST_ROW;
        end
        ST_ROW: begin
          wb_valid_q <= 1'b1;
          wb_idx_q   <= i_q;
          if (i_last) begin
            state_q <= ST_DRAIN;
          end else begin
            i_q <= i_q + IdxW'(1);
          end
        end
        ST_DRAIN: begin
          wb_valid_q <= 1'b0;
          if (k_last) begin
            i_q     <= '0;
            state_q <= ST_EMIT_RD;
          end else begin
            k_q     <= k_q + IdxW'(1);
            state_q <= ST_PIV_RD;
          end
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_CAP;
        end
        ST_EMIT_CAP: begin
          out_row_q   <= rdata_q | (refl_q ? (DATA_W'(1) << i_q) : '0);
          out_num_q   <= ROW_NUM_W'(i_q);
          out_last_q  <= i_last;
          out_valid_q <= 1'b1;
          state_q     <= ST_EMIT_SEND;
        end
        ST_EMIT_SEND: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= ST_LOAD;
            end else begin
              i_q     <= i_q + IdxW'(1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
